// ===== rtl/avc_pkg.sv =====
// Package for the arrowhead vertex block: CORDIC angle table, fixed widths,
// register indexes. No dependencies; imported by every avc_* module.

package avc_pkg;

  // CORDIC depth, shared by the vectoring and the rotation pipelines
  localparam int CORDIC_STEPS = 30;

  // angle formats: 16-bit turn for results, 32-bit turn inside CORDIC
  localparam int ANG_W  = 16;
  localparam int TURN_W = 32;

  // configuration register widths
  localparam int HL_W       = 16;
  localparam int HA_W       = 15;
  localparam int CFG_DATA_W = 16;
  localparam int REG_IDX_W  = 1;

  // rotation datapath: head_length / K in Q30, plus headroom
  localparam int ROT_W       = 48;
  localparam int ROT_Z_W     = 33;
  localparam int ROUND_SHIFT = 30;

  // vector magnitude pre-scale before the vectoring CORDIC
  localparam int PRE_SHIFT = 20;

  // 1/K in Q32
  localparam logic [31:0] KINV_Q32 = 32'h9B74_EDA8;

  localparam logic [ANG_W-1:0]  HALF_TURN16    = 16'h8000;
  localparam logic [ANG_W-1:0]  QUARTER_TURN16 = 16'h4000;
  localparam logic [TURN_W-1:0] HALF_TURN32    = 32'h8000_0000;

  localparam logic [HL_W-1:0] HL_RESET = 16'd160;
  localparam logic [HA_W-1:0] HA_RESET = 15'd5215;

  // register indexes of the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEAD_LENGTH     = 1'b0,
    REG_HEAD_HALF_ANGLE = 1'b1
  } reg_idx_e;

  // atan(2^-i) in units of a turn / 2^32
  localparam logic [TURN_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage

// ===== rtl/avc_vec_stage.sv =====
// One registered iteration of the vectoring CORDIC (atan2 of a vector).
// Depends on avc_pkg for the angle table.

module avc_vec_stage import avc_pkg::*; #(
  parameter int WIDTH = 40,
  parameter int STEP  = 0
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [WIDTH-1:0]  x_i,
  input  logic signed [WIDTH-1:0]  y_i,
  input  logic [TURN_W-1:0]        z_i,
  output logic signed [WIDTH-1:0]  x_o,
  output logic signed [WIDTH-1:0]  y_o,
  output logic [TURN_W-1:0]        z_o
);

  localparam logic [TURN_W-1:0] AngStep = ATAN_TURN[STEP];

  logic signed [WIDTH-1:0] x_d, y_d, x_q, y_q;
  logic [TURN_W-1:0]       z_d, z_q;

  // drive y toward zero; rotation direction from the sign of y
  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + (y_i >>> STEP);
      y_d = y_i - (x_i >>> STEP);
      z_d = z_i + AngStep;
    end else begin
      x_d = x_i - (y_i >>> STEP);
      y_d = y_i + (x_i >>> STEP);
      z_d = z_i - AngStep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== rtl/avc_rot_stage.sv =====
// One registered iteration of the rotation CORDIC (scaled cos/sin).
// Depends on avc_pkg for the angle table and datapath widths.

module avc_rot_stage import avc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [ROT_W-1:0]    x_i,
  input  logic signed [ROT_W-1:0]    y_i,
  input  logic signed [ROT_Z_W-1:0]  z_i,
  output logic signed [ROT_W-1:0]    x_o,
  output logic signed [ROT_W-1:0]    y_o,
  output logic signed [ROT_Z_W-1:0]  z_o
);

  localparam logic signed [ROT_Z_W-1:0] AngStep = ROT_Z_W'(ATAN_TURN[STEP]);

  logic signed [ROT_W-1:0]   x_d, y_d, x_q, y_q;
  logic signed [ROT_Z_W-1:0] z_d, z_q;

  // drive the residual angle toward zero
  always_comb begin
    if (z_i >= 0) begin
      x_d = x_i - (y_i >>> STEP);
      y_d = y_i + (x_i >>> STEP);
      z_d = z_i - AngStep;
    end else begin
      x_d = x_i + (y_i >>> STEP);
      y_d = y_i - (x_i >>> STEP);
      z_d = z_i + AngStep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== rtl/arrowhead_vertex_calc.sv =====
// Arrowhead vertex pipeline: an input word passes the setup, vectoring CORDIC,
// angle, rotation CORDIC and round/add stages in order. Throughput one word
// per cycle while m_axis_tready does not stall it; each CORDIC iteration is its
// own register stage. A one-word input skid buffer keeps s_axis_tready
// registered. Reset clears valid bits and loads head_length = 160 and
// head_half_angle = 5215; no clearing pass. Depends on avc_pkg.

module arrowhead_vertex_calc import avc_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: start_x, start_y, end_x, end_y (COORD_WIDTH each, from bit 0 up)
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata: left_x, left_y, right_x, right_y (COORD_WIDTH each, from bit 0 up)
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [REG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int Cw        = COORD_WIDTH;
  localparam int DataW     = ((4*COORD_WIDTH+7)/8)*8;
  localparam int PackW     = 4*COORD_WIDTH;
  localparam int DiffW     = COORD_WIDTH + 1;
  localparam int VecW      = DiffW + PRE_SHIFT + 3;
  localparam int OffW      = ROT_W + 1 - ROUND_SHIFT;
  localparam int SumW      = ((COORD_WIDTH > OffW) ? COORD_WIDTH : OffW) + 1;
  localparam int NumStages = 2*CORDIC_STEPS + 6;
  localparam int TipDepth  = NumStages - 1;

  localparam logic signed [SumW-1:0] SatHi = SumW'((64'sd1 <<< (COORD_WIDTH-1)) - 64'sd1);
  localparam logic signed [SumW-1:0] SatLo = -SatHi - SumW'(1);
  localparam logic signed [ROT_W:0]  RoundHalf = (ROT_W+1)'(64'sd1 <<< (ROUND_SHIFT-1));

  // ---------------------------------------------------------------------
  // configuration registers and the scaled start length
  logic [HL_W-1:0]   hl_q;
  logic [HA_W-1:0]   ha_q;
  logic [HL_W+31:0]  kprod;
  logic signed [ROT_W-1:0] kx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q <= HL_RESET;
      ha_q <= HA_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_HEAD_LENGTH:     hl_q <= cfg_data_i[HL_W-1:0];
        REG_HEAD_HALF_ANGLE: ha_q <= cfg_data_i[HA_W-1:0];
        default: ;
      endcase
    end
  end

  // head_length / K in Q30, stable long before the rotation stages read it
  assign kprod = hl_q * KINV_Q32;

  always_ff @(posedge clk_i) begin
    kx_q <= ROT_W'(kprod[HL_W+31:2]);
  end

  // ---------------------------------------------------------------------
  // input skid buffer and pipeline advance
  logic                 en;
  logic                 skid_vld_q;
  logic [PackW-1:0]     skid_data_q;
  logic                 in_vld;
  logic [PackW-1:0]     in_data;
  logic [NumStages-1:0] vld_q;

  assign en            = !vld_q[NumStages-1] || m_axis_tready;
  assign s_axis_tready = !skid_vld_q;
  assign in_vld        = skid_vld_q || s_axis_tvalid;
  assign in_data       = skid_vld_q ? skid_data_q : s_axis_tdata[PackW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (s_axis_tvalid && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && !skid_vld_q) begin
      skid_data_q <= s_axis_tdata[PackW-1:0];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_vld};
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: segment deltas, zero-length flag
  logic signed [Cw-1:0]    sx, sy, ex, ey;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic [CORDIC_STEPS+1:0] zero_q;
  logic [2*Cw-1:0]         tip_q [TipDepth];

  assign sx = in_data[Cw-1:0];
  assign sy = in_data[2*Cw-1:Cw];
  assign ex = in_data[3*Cw-1:2*Cw];
  assign ey = in_data[4*Cw-1:3*Cw];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q     <= {ex[Cw-1], ex} - {sx[Cw-1], sx};
      dy_q     <= {ey[Cw-1], ey} - {sy[Cw-1], sy};
      zero_q   <= {zero_q[CORDIC_STEPS:0], (ex == sx) && (ey == sy)};
      tip_q[0] <= {ey, ex};
      for (int k = 1; k < TipDepth; k++) begin
        tip_q[k] <= tip_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: fold the left half plane, scale up
  logic signed [VecW-1:0]  vx [CORDIC_STEPS+1];
  logic signed [VecW-1:0]  vy [CORDIC_STEPS+1];
  logic [TURN_W-1:0]       vz [CORDIC_STEPS+1];
  logic signed [DiffW-1:0] ax, ay;
  logic                    xneg;

  assign xneg = dx_q[DiffW-1];
  assign ax   = xneg ? -dx_q : dx_q;
  assign ay   = xneg ? -dy_q : dy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx[0] <= {{3{ax[DiffW-1]}}, ax, {PRE_SHIFT{1'b0}}};
      vy[0] <= {{3{ay[DiffW-1]}}, ay, {PRE_SHIFT{1'b0}}};
      vz[0] <= xneg ? HALF_TURN32 : '0;
    end
  end

  // stages 2..31: vectoring CORDIC
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    avc_vec_stage #(
      .WIDTH (VecW),
      .STEP  (i)
    ) u_vec (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[i]),
      .y_i   (vy[i]),
      .z_i   (vz[i]),
      .x_o   (vx[i+1]),
      .y_o   (vy[i+1]),
      .z_o   (vz[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // stage 32: round atan2 to 16 bits, back direction, side angles
  logic [ANG_W-1:0] atan16, back16;
  logic [ANG_W-1:0] ang_q [2];

  assign atan16 = zero_q[CORDIC_STEPS+1] ? '0 :
                  vz[CORDIC_STEPS][TURN_W-1:ANG_W] + ANG_W'(vz[CORDIC_STEPS][ANG_W-1]);
  assign back16 = atan16 + HALF_TURN16;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= back16 - {1'b0, ha_q};
      ang_q[1] <= back16 + {1'b0, ha_q};
    end
  end

  // stage 33: reduce to [-pi/2, pi/2), seed the rotation
  logic signed [ROT_W-1:0]   rx [2][CORDIC_STEPS+1];
  logic signed [ROT_W-1:0]   ry [2][CORDIC_STEPS+1];
  logic signed [ROT_Z_W-1:0] rz [2][CORDIC_STEPS+1];
  logic [1:0]                flip_q [CORDIC_STEPS+1];
  logic [1:0]                flip;
  logic [ANG_W-1:0]          qsum [2];
  logic [ANG_W-1:0]          za [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qsum[l] = ang_q[l] + QUARTER_TURN16;
      flip[l] = qsum[l][ANG_W-1];
      za[l]   = ang_q[l] ^ {flip[l], {(ANG_W-1){1'b0}}};
    end
  end

  // lane seeds written at fixed indexes; later taps come from the stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      rx[0][0] <= kx_q;
      rx[1][0] <= kx_q;
      ry[0][0] <= '0;
      ry[1][0] <= '0;
      rz[0][0] <= {za[0][ANG_W-1], za[0], {(TURN_W-ANG_W){1'b0}}};
      rz[1][0] <= {za[1][ANG_W-1], za[1], {(TURN_W-ANG_W){1'b0}}};
      flip_q[0] <= flip;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        flip_q[k] <= flip_q[k-1];
      end
    end
  end

  // stages 34..63: rotation CORDIC, one lane per vertex
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      avc_rot_stage #(
        .STEP (i)
      ) u_rot (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (rx[l][i]),
        .y_i   (ry[l][i]),
        .z_i   (rz[l][i]),
        .x_o   (rx[l][i+1]),
        .y_o   (ry[l][i+1]),
        .z_o   (rz[l][i+1])
      );
    end
  end

  // ---------------------------------------------------------------------
  // stage 64: undo the half-turn fold and round to whole pixels
  logic signed [ROT_W:0]   rnd_x [2];
  logic signed [ROT_W:0]   rnd_y [2];
  logic signed [OffW-1:0]  off_x_q [2];
  logic signed [OffW-1:0]  off_y_q [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (flip_q[CORDIC_STEPS][l]) begin
        rnd_x[l] = RoundHalf - (ROT_W+1)'(rx[l][CORDIC_STEPS]);
        rnd_y[l] = RoundHalf - (ROT_W+1)'(ry[l][CORDIC_STEPS]);
      end else begin
        rnd_x[l] = (ROT_W+1)'(rx[l][CORDIC_STEPS]) + RoundHalf;
        rnd_y[l] = (ROT_W+1)'(ry[l][CORDIC_STEPS]) + RoundHalf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        off_x_q[l] <= rnd_x[l][ROT_W:ROUND_SHIFT];
        off_y_q[l] <= rnd_y[l][ROT_W:ROUND_SHIFT];
      end
    end
  end

  // stage 65: tip plus offset, saturate, output register
  logic signed [Cw-1:0]   tip_x, tip_y;
  logic signed [SumW-1:0] sum_x [2];
  logic signed [SumW-1:0] sum_y [2];
  logic signed [Cw-1:0]   sat_x [2];
  logic signed [Cw-1:0]   sat_y [2];
  logic [Cw-1:0]          res_q [4];

  assign tip_x = tip_q[TipDepth-1][Cw-1:0];
  assign tip_y = tip_q[TipDepth-1][2*Cw-1:Cw];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum_x[l] = SumW'(tip_x) + SumW'(off_x_q[l]);
      sum_y[l] = SumW'(tip_y) + SumW'(off_y_q[l]);
      if (sum_x[l] > SatHi) begin
        sat_x[l] = Cw'(SatHi);
      end else if (sum_x[l] < SatLo) begin
        sat_x[l] = Cw'(SatLo);
      end else begin
        sat_x[l] = Cw'(sum_x[l]);
      end
      if (sum_y[l] > SatHi) begin
        sat_y[l] = Cw'(SatHi);
      end else if (sum_y[l] < SatLo) begin
        sat_y[l] = Cw'(SatLo);
      end else begin
        sat_y[l] = Cw'(sum_y[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q[0] <= sat_x[0];
      res_q[1] <= sat_y[0];
      res_q[2] <= sat_x[1];
      res_q[3] <= sat_y[1];
    end
  end

  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = DataW'({res_q[3], res_q[2], res_q[1], res_q[0]});

  // ---------------------------------------------------------------------
  // checks

  // a buffered word always drains on the next advance
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && en |=> !skid_vld_q)
    else $error("skid word not drained on advance");

  // a stalled pipeline keeps every valid bit
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

  // a result appears only behind a valid word in the rounding stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid ##1 m_axis_tvalid |-> $past(vld_q[NumStages-2]))
    else $error("result valid without source word");

endmodule

// ===== dv/tb_arrowhead_vertex_calc.sv =====
// Self-checking testbench for arrowhead_vertex_calc: a bit-exact CORDIC predictor
// inside a small scoreboard, streaming drivers with random gaps and back-pressure.
// Depends on rtl/avc_pkg.sv and rtl/arrowhead_vertex_calc.sv.

module tb_arrowhead_vertex_calc;
  timeunit 1ns;
  timeprecision 1ps;

  import avc_pkg::reg_idx_e;
  import avc_pkg::REG_HEAD_LENGTH;
  import avc_pkg::REG_HEAD_HALF_ANGLE;
  import avc_pkg::REG_IDX_W;
  import avc_pkg::CFG_DATA_W;

  localparam int CW = 16;
  localparam int DW = ((4*CW+7)/8)*8;

  localparam int N_PHASES       = 7;
  localparam int PHASE_ITEMS    = 165;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int DRAIN_SLACK    = 100;
  localparam int MAX_PRINT      = 20;

  // CORDIC constants of the predictor
  localparam int           CORDIC_N   = 30;
  localparam logic [31:0]  RECIP_GAIN = 32'h9B74_EDA8;
  localparam longint       ROUND_HALF = 64'sd536870912;
  localparam logic [31:0]  ATAN_STEP [CORDIC_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // word layouts, first field in the lowest bits
  typedef struct packed {
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_x;
  } segment_t;

  typedef struct packed {
    logic signed [CW-1:0] right_y;
    logic signed [CW-1:0] right_x;
    logic signed [CW-1:0] left_y;
    logic signed [CW-1:0] left_x;
  } vertices_t;

  // predictor and store of expected vertex pairs
  class vertex_scoreboard;
    logic [15:0] head_len;
    logic [14:0] half_ang;
    vertices_t   due_q[$];
    int          mismatches;
    int          checked;
    int          noted;
    int          zero_len;
    int          saturated;

    function new();
      head_len = 16'd160;
      half_ang = 15'd5215;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_HEAD_LENGTH) begin
        head_len = data[15:0];
      end else if (idx == REG_HEAD_HALF_ANGLE) begin
        half_ang = data[14:0];  // upper bit dropped
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // back direction of the shaft, 16-bit turn
    function logic [15:0] back_dir(longint dx, longint dy);
      longint      x;
      longint      y;
      longint      t;
      logic [31:0] acc;
      logic [31:0] rnd;
      if (dx == 0 && dy == 0) begin
        zero_len++;
        return 16'h8000;
      end
      x = dx <<< 20;
      y = dy <<< 20;
      acc = 32'h0;
      // left half plane: pre-rotate by a half turn
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_N; i++) begin
        t = x;
        if (y > 0) begin
          x = x + (y >>> i);
          y = y - (t >>> i);
          acc = acc + ATAN_STEP[i];
        end else begin
          x = x - (y >>> i);
          y = y + (t >>> i);
          acc = acc - ATAN_STEP[i];
        end
      end
      rnd = acc + 32'h0000_8000;
      return rnd[31:16] + 16'h8000;
    endfunction

    function logic [15:0] clamp_coord(longint v);
      if (v > 32767) begin
        saturated++;
        return 16'h7FFF;
      end
      if (v < -32768) begin
        saturated++;
        return 16'h8000;
      end
      return v[15:0];
    endfunction

    // tip plus head_len along angle ang
    function void rotate_side(logic [15:0] ang, logic signed [15:0] tip_x,
                              logic signed [15:0] tip_y,
                              output logic [15:0] vx, output logic [15:0] vy);
      logic [31:0] za;
      logic [31:0] probe;
      logic [63:0] prod;
      bit          flip;
      longint      x;
      longint      y;
      longint      t;
      longint      z;
      za = {ang, 16'h0000};
      probe = za + 32'h4000_0000;
      flip = probe[31];
      // outside [-pi/2, pi/2): fold by a half turn, negate afterwards
      if (flip) za = za - 32'h8000_0000;
      z = longint'($signed(za));
      prod = 64'(head_len) * 64'(RECIP_GAIN);
      x = longint'(prod >> 2);
      y = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
        t = x;
        if (z >= 0) begin
          x = x - (y >>> i);
          y = y + (t >>> i);
          z = z - longint'(ATAN_STEP[i]);
        end else begin
          x = x + (y >>> i);
          y = y - (t >>> i);
          z = z + longint'(ATAN_STEP[i]);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      x = (x + ROUND_HALF) >>> 30;
      y = (y + ROUND_HALF) >>> 30;
      vx = clamp_coord(longint'(tip_x) + x);
      vy = clamp_coord(longint'(tip_y) + y);
    endfunction

    function void note_segment(segment_t s);
      vertices_t   v;
      logic [15:0] back;
      logic [15:0] ang_l;
      logic [15:0] ang_r;
      logic [15:0] ox;
      logic [15:0] oy;
      back  = back_dir(longint'(s.end_x) - longint'(s.start_x),
                       longint'(s.end_y) - longint'(s.start_y));
      ang_l = back - {1'b0, half_ang};
      ang_r = back + {1'b0, half_ang};
      rotate_side(ang_l, s.end_x, s.end_y, ox, oy);
      v.left_x = ox;
      v.left_y = oy;
      rotate_side(ang_r, s.end_x, s.end_y, ox, oy);
      v.right_x = ox;
      v.right_y = oy;
      due_q.push_back(v);
      noted++;
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        flag_mismatch($sformatf("word %0d %s got %0d want %0d", checked, name,
                                $signed(got), $signed(want)));
      end
    endtask

    task check_vertices(vertices_t got);
      vertices_t want;
      if (due_q.size() == 0) begin
        flag_mismatch($sformatf("result word %h with nothing outstanding", got));
        return;
      end
      want = due_q.pop_front();
      compare_field("left_x",  got.left_x,  want.left_x);
      compare_field("left_y",  got.left_y,  want.left_y);
      compare_field("right_x", got.right_x, want.right_x);
      compare_field("right_y", got.right_y, want.right_y);
      checked++;
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // tdata: start_x, start_y, end_x, end_y
  logic [DW-1:0]         s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: left_x, left_y, right_x, right_y
  logic [DW-1:0]         m_axis_tdata;
  logic                  cfg_we_i;
  logic [REG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  vertex_scoreboard sb = new();

  bit gaps_on;
  bit stalls_on;
  bit hold_off_req;
  int hold_offs;
  int in_stalls;
  int settings_used;

  arrowhead_vertex_calc #(
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watch both streams and the register port
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(reg_idx_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_segment(segment_t'(s_axis_tdata));
      if (s_axis_tvalid && !s_axis_tready) in_stalls++;
      if (m_axis_tvalid && m_axis_tready) sb.check_vertices(vertices_t'(m_axis_tdata));
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk_i);
        hold_off_req = 1'b0;
        hold_offs++;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // offer one segment word, return at the accepting edge with tvalid still high
  task automatic send_segment(segment_t seg);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seg;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // both registers, back to back; only while the pipeline is empty
  task automatic program_head(logic [15:0] len, logic [15:0] ang);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_HEAD_LENGTH;
    cfg_data_i  <= len;
    @(posedge clk_i);
    cfg_index_i <= REG_HEAD_HALF_ANGLE;
    cfg_data_i  <= ang;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  function automatic segment_t make_segment(int sx, int sy, int ex, int ey);
    segment_t s;
    s.start_x = 16'(sx);
    s.start_y = 16'(sy);
    s.end_x   = 16'(ex);
    s.end_y   = 16'(ey);
    return s;
  endfunction

  function automatic logic [15:0] pull_back(logic signed [15:0] tip, int d);
    longint v;
    v = longint'(tip) - d;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // half short, zero-length or edge-hugging shafts, the rest full range
  function automatic segment_t random_segment();
    segment_t s;
    int       kind;
    int       ddx;
    int       ddy;
    kind = $urandom_range(0, 9);
    s = segment_t'({$urandom, $urandom});
    ddx = 0;
    ddy = 0;
    case (kind)
      4, 5: begin
        ddx = $urandom_range(0, 80) - 40;
        ddy = $urandom_range(0, 80) - 40;
      end
      7: begin
        s.end_x = $urandom_range(0, 1) ? 16'(32767 - $urandom_range(0, 63))
                                       : 16'(-32768 + $urandom_range(0, 63));
        s.end_y = $urandom_range(0, 1) ? 16'(32767 - $urandom_range(0, 63))
                                       : 16'(-32768 + $urandom_range(0, 63));
      end
      8: begin
        if ($urandom_range(0, 1)) s.end_x = s.start_x;
        else s.end_y = s.start_y;
      end
      9: begin
        ddx = $urandom_range(0, 4) - 2;
        ddy = $urandom_range(0, 4) - 2;
      end
      default: ;
    endcase
    // short shafts and zero-length: start derived from the tip
    if (kind == 4 || kind == 5 || kind == 6 || kind == 9) begin
      s.start_x = pull_back(s.end_x, ddx);
      s.start_y = pull_back(s.end_y, ddy);
    end
    return s;
  endfunction

  task automatic run_directed();
    send_segment(make_segment(0, 0, 0, 0));                  // zero length
    send_segment(make_segment(32767, -32768, 32767, -32768)); // zero length at a corner
    send_segment(make_segment(0, 0, 100, 0));
    send_segment(make_segment(0, 0, -100, 0));               // left half plane
    send_segment(make_segment(0, 0, 0, 100));
    send_segment(make_segment(0, 0, 0, -100));
    send_segment(make_segment(-1, 0, 0, 0));
    send_segment(make_segment(1, 0, 0, 0));
    send_segment(make_segment(0, 1, 0, 0));
    send_segment(make_segment(0, -1, 0, 0));
    send_segment(make_segment(1, -1, 0, 0));
    send_segment(make_segment(0, 0, 37, 37));
    send_segment(make_segment(-32768, -32768, 32767, 32767)); // widest deltas
    send_segment(make_segment(32767, 32767, -32768, -32768));
    send_segment(make_segment(32767, -32768, -32768, 32767));
    send_segment(make_segment(-32768, 32767, 32767, -32768));
    send_segment(make_segment(32767, 0, 32767, 32767));      // sides clip at the top right
    send_segment(make_segment(-32768, 0, -32768, -32768));   // sides clip at the bottom left
    send_segment(make_segment(0, 32767, 32767, 32767));
    send_segment(make_segment(0, -32768, -32768, -32768));
  endtask

  // stimulus: register settings per phase, directed words, then random words
  initial begin
    logic [15:0] len;
    logic [15:0] ang;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_HEAD_LENGTH;
    cfg_data_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain_pipeline();
        case (p)
          1: begin len = 16'd0;     ang = 16'd0;     end
          2: begin len = 16'hFFFF;  ang = 16'h7FFF;  end
          3: begin
            len = 16'($urandom_range(1, 4000));
            ang = 16'h8000 | 16'($urandom_range(0, 32767));  // top bit is dropped
          end
          4: begin len = 16'd1;     ang = 16'h4000;  end
          5: begin len = 16'($urandom); ang = 16'($urandom_range(0, 32767)); end
          default: begin len = 16'd160; ang = 16'd5215; end
        endcase
        program_head(len, ang);
      end
      if (p == 0) begin
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_directed();
      end
      // long output hold-off while the input keeps offering
      if (p == 2) hold_off_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          gaps_on   = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
          stalls_on = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        send_segment(random_segment());
      end
    end
    drain_pipeline();
    repeat (DRAIN_SLACK) @(posedge clk_i);
    $display("covered %0d segments (%0d zero-length) over %0d register settings,",
             sb.noted, sb.zero_len, settings_used + 1);
    $display("%0d clipped vertex coordinates, %0d input stall cycles, %0d long hold-offs",
             sb.saturated, in_stalls, hold_offs);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== arrowhead_vertex_calc.f =====
rtl/avc_pkg.sv
rtl/avc_vec_stage.sv
rtl/avc_rot_stage.sv
rtl/arrowhead_vertex_calc.sv
dv/tb_arrowhead_vertex_calc.sv
